@@ hw/rtl/kpd_pkg.sv @@
// Shared types, constants and the key-to-ASCII table for the keypad press detector.
package kpd_pkg;

  localparam int unsigned SCAN_W = 16;
  localparam int unsigned CODE_W = 7;
  localparam int unsigned DUTY_W = 8;

  // Duty compare value after reset.
  localparam logic [DUTY_W-1:0] DUTY_RESET = 8'hFF;

  // Key codes that adjust the duty value.
  localparam logic [CODE_W-1:0] KEY_NONE = 7'h00;
  localparam logic [CODE_W-1:0] KEY_UP   = 7'h31;
  localparam logic [CODE_W-1:0] KEY_DOWN = 7'h32;

  // Result of evaluating one scan pair against the held mask.
  typedef struct packed {
    logic              new_press;
    logic [CODE_W-1:0] key_code;
  } kpd_res_t;

  // ASCII code for each key position, bit 0 first.
  function automatic logic [CODE_W-1:0] key_ascii(input logic [3:0] idx);
    logic [CODE_W-1:0] code;
    case (idx)
      4'd0:    code = 7'h2A; // '*'
      4'd1:    code = 7'h30; // '0'
      4'd2:    code = 7'h23; // '#'
      4'd3:    code = 7'h44; // 'D'
      4'd4:    code = 7'h37; // '7'
      4'd5:    code = 7'h38; // '8'
      4'd6:    code = 7'h39; // '9'
      4'd7:    code = 7'h43; // 'C'
      4'd8:    code = 7'h34; // '4'
      4'd9:    code = 7'h35; // '5'
      4'd10:   code = 7'h36; // '6'
      4'd11:   code = 7'h42; // 'B'
      4'd12:   code = 7'h31; // '1'
      4'd13:   code = 7'h32; // '2'
      4'd14:   code = 7'h33; // '3'
      default: code = 7'h41; // 'A'
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/keypad_press_detect_duty_adjust_top.sv @@
// Top level of the debounced keypad press detector with duty adjustment.
//
// Input channel: in_valid/in_stall with two 16-bit scans of the 4x4 keypad
// taken one debounce interval apart (row 1 in bits 15..12). Output channel:
// out_valid/out_stall with new_press, key_code (ASCII of the lowest new key,
// zero if none) and duty_level, one result for every input transfer.
// An input transfer lands in an input register; from there the scans are
// ANDed, compared with the held mask, encoded and the duty value adjusted, and
// the result is written to the output register once it is free. An item
// passes the input register and then the output register before out_valid
// rises, and one item is taken every cycle as long as the output is drained.
// When the receiver stalls, the output register holds its result and the
// input register fills; in_stall then rises only while both are full.
// The held mask and duty value change only as an item moves to the output.
// Reset (rst_n low, synchronous) empties both registers, clears the held
// mask and sets the duty value to 255.
module keypad_press_detect_duty_adjust_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kpd_pkg::SCAN_W-1:0] in_scan_first,
  input  logic [kpd_pkg::SCAN_W-1:0] in_scan_second,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_new_press,
  output logic [kpd_pkg::CODE_W-1:0] out_key_code,
  output logic [kpd_pkg::DUTY_W-1:0] out_duty_level
);

  logic                       in_valid_r;
  logic [kpd_pkg::SCAN_W-1:0] scan_first_r;
  logic [kpd_pkg::SCAN_W-1:0] scan_second_r;
  logic                       out_valid_r;
  logic                       new_press_r;
  logic [kpd_pkg::CODE_W-1:0] key_code_r;
  logic [kpd_pkg::SCAN_W-1:0] stable_mask_r;
  logic [kpd_pkg::DUTY_W-1:0] duty_r;
  logic [kpd_pkg::DUTY_W-1:0] duty_nxt;
  logic [kpd_pkg::SCAN_W-1:0] deb_mask;
  kpd_pkg::kpd_res_t          res;
  logic                       out_load;
  logic                       in_load;

  // Handshake: the output register loads when empty or being drained.
  assign out_load = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~out_load;
  assign in_load  = in_valid & ~in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= 1'b1;
    end else if (out_load) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      scan_first_r  <= in_scan_first;
      scan_second_r <= in_scan_second;
    end
  end

  // Debounce and encode against the held mask.
  kpd_enc u_enc (
    .scan_first  (scan_first_r),
    .scan_second (scan_second_r),
    .held_mask   (stable_mask_r),
    .deb_mask    (deb_mask),
    .res         (res)
  );

  // Key '1' raises the duty value and key '2' lowers it, both wrapping.
  always_comb begin
    duty_nxt = duty_r;
    if (res.key_code == kpd_pkg::KEY_UP) begin
      duty_nxt = duty_r + 8'd1;
    end else if (res.key_code == kpd_pkg::KEY_DOWN) begin
      duty_nxt = duty_r - 8'd1;
    end
  end

  // Block state advances with each item that reaches the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_mask_r <= '0;
      duty_r        <= kpd_pkg::DUTY_RESET;
    end else if (out_load) begin
      stable_mask_r <= deb_mask;
      duty_r        <= duty_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      new_press_r <= res.new_press;
      key_code_r  <= res.key_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_press  = new_press_r;
  assign out_key_code   = key_code_r;
  assign out_duty_level = duty_r;

  // The duty value and the held mask change only when a result is loaded.
  a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(duty_r))
    else $error("duty value changed without a result transfer");

  a_mask_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(stable_mask_r))
    else $error("held mask changed without a result transfer");

  // A key code is reported exactly when a new press is flagged.
  a_code_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (new_press_r == (key_code_r != kpd_pkg::KEY_NONE)))
    else $error("key code and new press flag disagree");

  // Duty moves by at most one step per result.
  a_duty_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (duty_r == $past(duty_r)) || (duty_r == $past(duty_r) + 8'd1)
                 || (duty_r == $past(duty_r) - 8'd1))
    else $error("duty value moved by more than one step");

endmodule

@@ hw/rtl/kpd_enc.sv @@
// Debounce, new-press detection and lowest-key priority encoder.
module kpd_enc (
  input  logic [kpd_pkg::SCAN_W-1:0] scan_first,
  input  logic [kpd_pkg::SCAN_W-1:0] scan_second,
  input  logic [kpd_pkg::SCAN_W-1:0] held_mask,
  output logic [kpd_pkg::SCAN_W-1:0] deb_mask,
  output kpd_pkg::kpd_res_t          res
);

  logic [kpd_pkg::SCAN_W-1:0] fresh;
  logic [3:0]                 low_idx;

  // A key counts as held only when both scans show it.
  assign deb_mask = scan_first & scan_second;
  assign fresh    = deb_mask & ~held_mask;

  // Find the lowest set bit; scanning downward lets lower bits win.
  always_comb begin
    low_idx = 4'd0;
    for (int i = kpd_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        low_idx = 4'(i);
      end
    end
  end

  // Encode to ASCII, or zero when nothing new was pressed.
  always_comb begin
    res.new_press = |fresh;
    res.key_code  = (|fresh) ? kpd_pkg::key_ascii(low_idx) : kpd_pkg::KEY_NONE;
  end

endmodule
